// ===== hdl/piad_pkg.sv =====
`default_nettype none
package piad_pkg;

    // Limits and reset values
    localparam int MAX_COUNT = 65535;
    localparam logic [15:0] COUNT_LIMIT_RST = 16'hFFFF;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Register map (word index)
    localparam logic REG_COUNT_LIMIT = 1'b0;

    // Element / count type codes
    localparam logic [7:0] TYPE_ZERO = 8'd4;
    localparam logic [7:0] TYPE_S1 = 8'd5;
    localparam logic [7:0] TYPE_S2 = 8'd6;
    localparam logic [7:0] TYPE_S3 = 8'd7;
    localparam logic [7:0] TYPE_S4 = 8'd8;
    localparam logic [7:0] TYPE_S5 = 8'd9;
    localparam logic [7:0] TYPE_S6 = 8'd10;
    localparam logic [7:0] TYPE_S7 = 8'd11;
    localparam logic [7:0] TYPE_S8 = 8'd12;
    localparam logic [7:0] TYPE_U1 = 8'd13;
    localparam logic [7:0] TYPE_U4 = 8'd16;

    // Result kinds
    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_ELEM = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_NEG_COUNT = 2'd1;
    localparam logic [1:0] ERR_OVER_LIMIT = 2'd2;
    localparam logic [1:0] ERR_EARLY_END = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT,
        PH_ETYPE,
        PH_ELEM
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       final_req;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] value;
        logic [15:0]        repeat_res;
        logic               last;
        logic [1:0]         error_code;
    } t_res_item;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] num;
        t_res_item  res0;
        t_res_item  res1;
    } t_res_pair;

    // Byte width of a type code; zero-width for anything unknown
    function automatic logic [3:0] type_width(input logic [7:0] t);
        logic [3:0] w;
        w = 4'd0;
        case (t) inside
            [TYPE_S1:TYPE_S8]: w = 4'(t - TYPE_ZERO);
            [TYPE_U1:TYPE_U4]: w = 4'(t - TYPE_S8);
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // Sign extension for the signed types narrower than 64 bits
    function automatic logic [63:0] type_extend(input logic [7:0] t, input logic [63:0] acc);
        logic [63:0] r;
        r = acc;
        case (t)
            TYPE_S1: r = {{56{acc[7]}}, acc[7:0]};
            TYPE_S2: r = {{48{acc[15]}}, acc[15:0]};
            TYPE_S3: r = {{40{acc[23]}}, acc[23:0]};
            TYPE_S4: r = {{32{acc[31]}}, acc[31:0]};
            TYPE_S5: r = {{24{acc[39]}}, acc[39:0]};
            TYPE_S6: r = {{16{acc[47]}}, acc[47:0]};
            TYPE_S7: r = {{8{acc[55]}}, acc[55:0]};
            default: r = acc;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/piad_cfg.sv =====
`default_nettype none
module piad_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [15:0]      o_count_limit
);

    logic [15:0] r_count_limit;
    logic        wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == piad_pkg::REG_COUNT_LIMIT);

    // Count limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= piad_pkg::COUNT_LIMIT_RST;
        end else if (wr_hit) begin
            r_count_limit <= pwdata[15:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == piad_pkg::REG_COUNT_LIMIT) begin
            prdata = {16'd0, r_count_limit};
        end
    end

    assign pready = 1'b1;
    assign o_count_limit = r_count_limit;

endmodule
`default_nettype wire

// ===== hdl/piad_dec.sv =====
`default_nettype none
module piad_dec (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire piad_pkg::t_req_item  i_item,
    input  wire logic [15:0]          i_count_limit,
    output piad_pkg::t_res_pair       o_res
);

    piad_pkg::t_phase r_phase, n_phase, ph_mid;
    logic [7:0]  r_cur_type, n_cur_type;
    logic [3:0]  r_bytes_left, n_bytes_left;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_elems, n_elems;
    logic [7:0]  r_elem_type, n_elem_type;

    logic [7:0]  in_b;
    logic [7:0]  work_type;
    logic [3:0]  work_w;
    logic [3:0]  in_w;
    logic [3:0]  bl_dec;
    logic [2:0]  pos;
    logic [63:0] merged;
    logic [63:0] ext;
    logic [63:0] cv;
    logic        cd;
    logic        cnt_neg;
    logic        cnt_over;

    piad_pkg::t_res_item prim, err_item;
    logic prim_valid, err_valid;

    // Shared byte merge and count checks
    assign in_b      = i_item.data_byte;
    assign in_w      = piad_pkg::type_width(in_b);
    assign work_type = (r_phase == piad_pkg::PH_COUNT) ? r_cur_type : r_elem_type;
    assign work_w    = piad_pkg::type_width(work_type);
    assign bl_dec    = r_bytes_left - 4'd1;
    assign pos       = 3'(work_w - r_bytes_left);
    assign merged    = r_acc | ({56'd0, in_b} << {pos, 3'b000});
    assign ext       = piad_pkg::type_extend(work_type, merged);
    assign cv        = i_item.start_req ? 64'd0 : ext;
    assign cd        = i_item.start_req ? (in_w == 4'd0)
                                        : ((r_phase == piad_pkg::PH_COUNT) && (bl_dec == 4'd0));
    assign cnt_neg   = cv[63];
    assign cnt_over  = (cv > {48'd0, i_count_limit}) || (cv > 64'(piad_pkg::MAX_COUNT));

    // Next phase
    always_comb begin
        ph_mid = r_phase;
        if (i_item.start_req) begin
            ph_mid = piad_pkg::PH_COUNT;
        end else begin
            case (r_phase)
                piad_pkg::PH_ETYPE: begin
                    if ((r_elems == 16'd0) || (in_w == 4'd0)) begin
                        ph_mid = piad_pkg::PH_IDLE;
                    end else begin
                        ph_mid = piad_pkg::PH_ELEM;
                    end
                end
                piad_pkg::PH_ELEM: begin
                    if ((bl_dec == 4'd0) && (r_elems == 16'd1)) begin
                        ph_mid = piad_pkg::PH_IDLE;
                    end
                end
                default: ph_mid = r_phase;
            endcase
        end
        if (cd) begin
            ph_mid = (cnt_neg || cnt_over) ? piad_pkg::PH_IDLE : piad_pkg::PH_ETYPE;
        end

        n_phase = r_phase;
        if (i_fire) begin
            n_phase = (i_item.final_req && (ph_mid != piad_pkg::PH_IDLE))
                    ? piad_pkg::PH_IDLE : ph_mid;
        end
    end

    // Datapath next values and results
    always_comb begin
        n_cur_type   = r_cur_type;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_elems      = r_elems;
        n_elem_type  = r_elem_type;
        prim         = '0;
        prim_valid   = 1'b0;
        err_item     = '0;
        err_valid    = 1'b0;

        if (i_fire) begin
            if (i_item.start_req) begin
                n_cur_type   = in_b;
                n_acc        = 64'd0;
                n_elems      = 16'd0;
                n_bytes_left = in_w;
            end else begin
                case (r_phase)
                    piad_pkg::PH_COUNT: begin
                        n_acc        = merged;
                        n_bytes_left = bl_dec;
                    end
                    piad_pkg::PH_ETYPE: begin
                        n_elem_type = in_b;
                        n_acc       = 64'd0;
                        if (r_elems == 16'd0) begin
                            prim_valid = 1'b1;
                            prim.kind  = piad_pkg::KIND_EMPTY;
                            prim.last  = 1'b1;
                        end else if (in_w == 4'd0) begin
                            // zero-width elements: one run result
                            prim_valid      = 1'b1;
                            prim.kind       = piad_pkg::KIND_ELEM;
                            prim.repeat_res = r_elems;
                            prim.last       = 1'b1;
                            n_elems         = 16'd0;
                        end else begin
                            n_bytes_left = in_w;
                        end
                    end
                    piad_pkg::PH_ELEM: begin
                        n_acc        = merged;
                        n_bytes_left = bl_dec;
                        if (bl_dec == 4'd0) begin
                            n_elems         = r_elems - 16'd1;
                            prim_valid      = 1'b1;
                            prim.kind       = piad_pkg::KIND_ELEM;
                            prim.value      = ext;
                            prim.repeat_res = 16'd1;
                            prim.last       = (r_elems == 16'd1);
                            n_acc           = 64'd0;
                            if (r_elems != 16'd1) begin
                                n_bytes_left = work_w;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Count complete: check and report
            if (cd) begin
                prim_valid = 1'b1;
                prim.last  = 1'b1;
                if (cnt_neg) begin
                    prim.kind       = piad_pkg::KIND_ERROR;
                    prim.error_code = piad_pkg::ERR_NEG_COUNT;
                end else if (cnt_over) begin
                    prim.kind       = piad_pkg::KIND_ERROR;
                    prim.error_code = piad_pkg::ERR_OVER_LIMIT;
                end else begin
                    prim.kind  = piad_pkg::KIND_COUNT;
                    prim.value = cv;
                    prim.last  = 1'b0;
                    n_elems    = cv[15:0];
                end
                n_bytes_left = 4'd0;
                n_acc        = 64'd0;
            end

            // Data ended before the array closed
            if (i_item.final_req && (ph_mid != piad_pkg::PH_IDLE)) begin
                err_valid           = 1'b1;
                err_item.kind       = piad_pkg::KIND_ERROR;
                err_item.last       = 1'b1;
                err_item.error_code = piad_pkg::ERR_EARLY_END;
                n_bytes_left        = 4'd0;
                n_acc               = 64'd0;
                n_elems             = 16'd0;
            end
        end
    end

    // Pack results in order
    always_comb begin
        o_res.num  = {1'b0, prim_valid} + {1'b0, err_valid};
        o_res.res0 = prim_valid ? prim : err_item;
        o_res.res1 = err_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= piad_pkg::PH_IDLE;
            r_cur_type   <= 8'd0;
            r_bytes_left <= 4'd0;
            r_acc        <= 64'd0;
            r_elems      <= 16'd0;
            r_elem_type  <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_cur_type   <= n_cur_type;
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_elems      <= n_elems;
            r_elem_type  <= n_elem_type;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/piad_resq.sv =====
`default_nettype none
module piad_resq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire piad_pkg::t_res_pair  i_push,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output piad_pkg::t_res_item       o_item
);

    localparam int PW = piad_pkg::RES_PTR_W;
    localparam int CW = piad_pkg::RES_CNT_W;

    piad_pkg::t_res_item r_ent [piad_pkg::RES_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] wr_ptr1;
    logic          pop;

    assign wr_ptr1 = r_wr_ptr + PW'(1);
    assign pop     = o_valid && i_ready;
    // two free slots needed for a worst-case request
    assign o_room  = (r_cnt <= CW'(piad_pkg::RES_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_ent[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.num);
        n_rd_ptr = pop ? (r_rd_ptr + PW'(1)) : r_rd_ptr;
        n_cnt    = r_cnt + CW'(i_push.num) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_ent[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_ent[wr_ptr1] <= i_push.res1;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/packed_int_array_decoder_top.sv =====
`default_nettype none
// Packed integer array decoder. Takes one byte per request (start_req marks the count
// type byte, final_req the last byte available) and returns the element count, then
// each element value sign- or zero-extended to 64 bits; an empty array gives an empty
// result, zero-width element types give one run result, and bad counts or early end
// give an error result. One byte is taken every cycle: the decode of a byte is a
// single pass between the input register and a four-entry result queue. A byte can
// give two results; the input stalls while the queue has fewer than two free entries.
// The output moves one result per cycle, so the input drops below one byte per cycle
// under output back-pressure, or when two-result bytes keep coming before the queue
// drains. count_limit sits at byte address 0 of the APB port and resets to 65535.
module packed_int_array_decoder_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire piad_pkg::t_req_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output piad_pkg::t_res_item       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic                r_in_valid;
    piad_pkg::t_req_item r_in_data;
    logic                fire;
    logic                room;
    logic [15:0]         count_limit;
    piad_pkg::t_res_pair res_pair;

    // Input register
    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    piad_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_count_limit (count_limit)
    );

    piad_dec u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in_data),
        .i_count_limit (count_limit),
        .o_res         (res_pair)
    );

    piad_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_pair),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== verif/piad_checker.sv =====
`default_nettype none
module piad_result_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire piad_pkg::t_req_item i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire piad_pkg::t_res_item i_out_data,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic                i_pready,
    input  wire logic [2:0]          i_paddr,
    input  wire logic [31:0]         i_pwdata,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import piad_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = {REG_COUNT_LIMIT, 2'b00};

    // Decoder image, updated on every accepted request
    t_phase      phase;
    logic [7:0]  cur_type;
    logic [7:0]  elem_type;
    logic [3:0]  bytes_left;
    logic [63:0] acc;
    logic [15:0] elems_left;
    logic [15:0] count_limit;

    t_res_item   pending_results[$];
    int          mismatch_count = 0;

    function automatic logic [3:0] byte_width(input logic [7:0] t);
        if (t >= TYPE_S1 && t <= TYPE_S8) begin
            return 4'(t - TYPE_ZERO);
        end
        if (t >= TYPE_U1 && t <= TYPE_U4) begin
            return 4'(t - TYPE_U1 + 8'd1);
        end
        return 4'd0;
    endfunction

    // Signed types below 8 bytes get the sign bit copied upward
    function automatic logic [63:0] sign_fill(input logic [7:0] t, input logic [63:0] a);
        int nbits;
        nbits = (int'(t) - int'(TYPE_ZERO)) * 8;
        if (t >= TYPE_S1 && t <= TYPE_S7) begin
            if (a[nbits-1]) begin
                a = a | ({64{1'b1}} << nbits);
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [63:0] value,
                               input logic [15:0] rep, input logic last,
                               input logic [1:0] err);
        t_res_item r;
        r.kind       = kind;
        r.value      = value;
        r.repeat_res = rep;
        r.last       = last;
        r.error_code = err;
        pending_results.push_back(r);
    endtask

    // Little-endian merge of the next byte of a count or element
    task automatic merge_byte(input logic [7:0] t, input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'(byte_width(t) - bytes_left);
        acc = acc | (64'(b) << (8 * pos));
        bytes_left = bytes_left - 4'd1;
    endtask

    task automatic finish_count(input logic [63:0] v);
        if (v[63]) begin
            push_result(KIND_ERROR, 64'd0, 16'd0, 1'b1, ERR_NEG_COUNT);
            phase = PH_IDLE;
        end else if (v > 64'(count_limit) || v > 64'(MAX_COUNT)) begin
            push_result(KIND_ERROR, 64'd0, 16'd0, 1'b1, ERR_OVER_LIMIT);
            phase = PH_IDLE;
        end else begin
            push_result(KIND_COUNT, v, 16'd0, 1'b0, ERR_NONE);
            elems_left = v[15:0];
            phase = PH_ETYPE;
        end
        bytes_left = 4'd0;
        acc = 64'd0;
    endtask

    task automatic decode_byte(input t_req_item r);
        logic [63:0] v;
        if (r.start_req) begin
            // a start always begins a fresh array, dropping any open one
            cur_type   = r.data_byte;
            acc        = 64'd0;
            elems_left = 16'd0;
            bytes_left = byte_width(cur_type);
            if (bytes_left == 4'd0) begin
                finish_count(64'd0);
            end else begin
                phase = PH_COUNT;
            end
        end else if (phase == PH_COUNT) begin
            merge_byte(cur_type, r.data_byte);
            if (bytes_left == 4'd0) begin
                finish_count(sign_fill(cur_type, acc));
            end
        end else if (phase == PH_ETYPE) begin
            elem_type = r.data_byte;
            acc = 64'd0;
            if (elems_left == 16'd0) begin
                push_result(KIND_EMPTY, 64'd0, 16'd0, 1'b1, ERR_NONE);
                phase = PH_IDLE;
            end else if (byte_width(elem_type) == 4'd0) begin
                // zero-width elements collapse into one run
                push_result(KIND_ELEM, 64'd0, elems_left, 1'b1, ERR_NONE);
                elems_left = 16'd0;
                phase = PH_IDLE;
            end else begin
                bytes_left = byte_width(elem_type);
                phase = PH_ELEM;
            end
        end else if (phase == PH_ELEM) begin
            merge_byte(elem_type, r.data_byte);
            if (bytes_left == 4'd0) begin
                v = sign_fill(elem_type, acc);
                elems_left = elems_left - 16'd1;
                push_result(KIND_ELEM, v, 16'd1, elems_left == 16'd0, ERR_NONE);
                acc = 64'd0;
                if (elems_left == 16'd0) begin
                    phase = PH_IDLE;
                end else begin
                    bytes_left = byte_width(elem_type);
                end
            end
        end
        // data ran out before the array closed
        if (r.final_req && phase != PH_IDLE) begin
            push_result(KIND_ERROR, 64'd0, 16'd0, 1'b1, ERR_EARLY_END);
            phase      = PH_IDLE;
            bytes_left = 4'd0;
            acc        = 64'd0;
            elems_left = 16'd0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res_item want;
        if (!i_rst_n) begin
            phase       = PH_IDLE;
            cur_type    = 8'd0;
            elem_type   = 8'd0;
            bytes_left  = 4'd0;
            acc         = 64'd0;
            elems_left  = 16'd0;
            count_limit = COUNT_LIMIT_RST;
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LIMIT_ADDR) begin
                count_limit = i_pwdata[15:0];
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d value %h",
                                              i_out_data.kind, i_out_data.value));
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.kind != want.kind) begin
                        report_mismatch($sformatf("kind: got %0d, expected %0d",
                                                  i_out_data.kind, want.kind));
                    end
                    if (i_out_data.value != want.value) begin
                        report_mismatch($sformatf("value: got %h, expected %h",
                                                  i_out_data.value, want.value));
                    end
                    if (i_out_data.repeat_res != want.repeat_res) begin
                        report_mismatch($sformatf("repeat_res: got %0d, expected %0d",
                                                  i_out_data.repeat_res, want.repeat_res));
                    end
                    if (i_out_data.last != want.last) begin
                        report_mismatch($sformatf("last: got %0d, expected %0d",
                                                  i_out_data.last, want.last));
                    end
                    if (i_out_data.error_code != want.error_code) begin
                        report_mismatch($sformatf("error_code: got %0d, expected %0d",
                                                  i_out_data.error_code, want.error_code));
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule
`default_nettype wire

// ===== verif/tb_packed_int_array_decoder_top.sv =====
`default_nettype none
module tb_packed_int_array_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import piad_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = {REG_COUNT_LIMIT, 2'b00};
    localparam logic [7:0] TYPE_U2    = TYPE_U1 + 8'd1;
    localparam int         SEG_ITEMS  = 290;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_req_item   in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_res_item   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    int tx_idle    = 0;
    int rx_idle    = 0;
    int cur_limit  = 65535;
    int items_sent = 0;
    int byte_idx;
    int cut_at;
    bit cut_final;
    bit cut_hit;

    always #4 clk = ~clk;

    packed_int_array_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    piad_result_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle);
    end

    function automatic int field_bytes(input logic [7:0] t);
        if (t >= TYPE_S1 && t <= TYPE_S8) return int'(t - TYPE_ZERO);
        if (t >= TYPE_U1 && t <= TYPE_U4) return int'(t - TYPE_U1) + 1;
        return 0;
    endfunction

    // One request, preceded by a random number of idle cycles
    task automatic send_req(input logic [7:0] b, input logic st, input logic fin);
        t_req_item r;
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < tx_idle) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.data_byte = b;
        r.start_req = st;
        r.final_req = fin;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Array byte; once the cut point is reached the rest of the array is dropped
    task automatic put_byte(input logic [7:0] b, input logic st, input logic fin);
        logic hit;
        if (!cut_hit) begin
            hit = (byte_idx == cut_at);
            send_req(b, st, fin || (hit && cut_final));
            cut_hit = hit;
            byte_idx++;
            items_sent++;
        end
    endtask

    task automatic send_array();
        logic [7:0]  ctype;
        logic [7:0]  etype;
        logic [63:0] cnt;
        int          cw;
        int          ew;
        int          n;
        int          p;
        bit          raw;
        bit          end_fin;
        p = $urandom_range(99);
        if (p < 4) begin
            // stray byte: dropped when idle, consumed after an abandoned array
            send_req(8'($urandom), 1'b0, 1'($urandom));
            return;
        end
        byte_idx  = 0;
        cut_hit   = 1'b0;
        cut_at    = ($urandom_range(99) < 12) ? $urandom_range(24) : -1;
        cut_final = 1'($urandom);
        end_fin   = ($urandom_range(99) < 6);

        // count type and count
        p = $urandom_range(99);
        if (p < 55) ctype = TYPE_U1;
        else if (p < 70) ctype = 8'($urandom_range(TYPE_U4, TYPE_U1));
        else if (p < 85) ctype = 8'($urandom_range(TYPE_S8, TYPE_S1));
        else if (p < 92) ctype = TYPE_ZERO;
        else ctype = 8'($urandom_range(255));
        cw  = field_bytes(ctype);
        raw = ($urandom_range(99) < 12);
        if (raw) cnt = {$urandom, $urandom};
        else if ($urandom_range(99) < 80) cnt = 64'($urandom_range(6));
        else cnt = 64'($urandom_range(20));
        if (cw == 0) begin
            cnt = 64'd0;
            raw = 1'b0;
        end
        put_byte(ctype, 1'b1, 1'b0);
        for (int i = 0; i < cw; i++) begin
            put_byte(cnt[8*i +: 8], 1'b0, 1'b0);
        end
        if (raw || cnt > 64'(cur_limit)) return;

        // element type and elements
        n = int'(cnt);
        p = $urandom_range(99);
        if (p < 65) etype = 8'($urandom_range(TYPE_U4, TYPE_S1));
        else if (p < 80) etype = TYPE_ZERO;
        else etype = 8'($urandom_range(255));
        ew = field_bytes(etype);
        put_byte(etype, 1'b0, end_fin && (n == 0 || ew == 0));
        if (ew == 0) return;
        for (int e = 0; e < n; e++) begin
            for (int j = 0; j < ew; j++) begin
                put_byte(8'($urandom), 1'b0, end_fin && e == n - 1 && j == ew - 1);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop requests, let every result drain, then cover the pipeline latency
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        logic [15:0] limits [0:5];
        limits = '{16'hFFFF, 16'd0, 16'd5, 16'($urandom_range(30, 1)), 16'd1, 16'hFFFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle = 21;
        rx_idle = 70;
        write_reg(LIMIT_ADDR, 32'h0000_FFFF);
        cur_limit = 65535;

        // directed: stray byte with final while idle is dropped
        send_req(8'hFF, 1'b0, 1'b1);
        // zero-width count, then the element type closes an empty array
        send_req(TYPE_ZERO, 1'b1, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        // signed 2-byte count of -1
        send_req(TYPE_S2, 1'b1, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        // largest count with an unknown element type: a single run result
        send_req(TYPE_U2, 1'b1, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        // count one past the maximum
        send_req(TYPE_U4, 1'b1, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        send_req(8'h01, 1'b0, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        // signed byte extremes
        send_req(TYPE_U1, 1'b1, 1'b0);
        send_req(8'h02, 1'b0, 1'b0);
        send_req(TYPE_S1, 1'b0, 1'b0);
        send_req(8'h80, 1'b0, 1'b0);
        send_req(8'h7F, 1'b0, 1'b0);
        // start drops an open array; final lands on the new count type
        send_req(TYPE_U1, 1'b1, 1'b0);
        send_req(8'h03, 1'b0, 1'b0);
        send_req(TYPE_U1, 1'b1, 1'b1);

        // random arrays over three idling modes, two limits each
        for (int m = 0; m < 3; m++) begin
            for (int s = 0; s < 2; s++) begin
                wait_drained();
                tx_idle = (m == 0) ? 21 : (m == 1) ? 70 : 0;
                rx_idle = (m == 0) ? 70 : (m == 1) ? 21 : 0;
                cur_limit = int'(limits[2*m + s]);
                write_reg(LIMIT_ADDR, 32'(limits[2*m + s]));
                items_sent = 0;
                while (items_sent < SEG_ITEMS) send_array();
            end
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
